[sv/hdn_pkg.sv]
// Shared types and codes for the handshake diffusion node.
package hdn_pkg;

	typedef enum logic [1:0] {
		ACT_RUN_START  = 2'd0,
		ACT_STEP_START = 2'd1,
		ACT_RX_MSG     = 2'd2,
		ACT_STEP_END   = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		HS_HELLO = 2'd0,
		HS_ACK   = 2'd1,
		HS_OK    = 2'd2
	} hs_t;

	localparam logic [1:0] MSG_HELLO = 2'd0;
	localparam logic [1:0] MSG_ACK   = 2'd1;
	localparam logic [1:0] MSG_OK    = 2'd2;

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_ID   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IS_SOURCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KAPPA     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MSGS  = 3'd4;

	localparam logic [7:0] WAIT_MAX        = 8'hFF;
	localparam logic [7:0] TIMEOUT_RESET   = 8'd50;
	localparam logic [3:0] MAX_MSGS_RESET  = 4'd6;

	// handshake and per-step bookkeeping
	typedef struct packed {
		hs_t        hs;
		logic [7:0] wait_steps;
		logic [3:0] msgs_seen;
		logic       step_closed;
		logic       linked;
	} hdn_ctrl_t;

endpackage

[sv/handshake_diffusion_node_core.sv]
// Top level: input stage, node state, result register and configuration registers.
// A beat accepted into the input register is stepped and, if it makes a result, moves
// on to the result register that drives m_tvalid. Throughput: one beat per cycle while
// s_tready is high; node state is updated on the edge that moves the beat onwards.
// s_tready drops only while a result waits in the result register and another is due.
// arst_n clears node state, handshake pipeline and configuration to their defaults.
module handshake_diffusion_node_core #(
	parameter int ID_BITS   = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [hdn_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [((ID_BITS > FRAC_BITS+1) ? ID_BITS : FRAC_BITS+1)-1:0] cfg_wdata,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// send_enable, rx_type, rx_sender, rx_recipient, rx_hello_id, rx_partner_msg,
	// rx_concentration
	input  logic [((4*ID_BITS+FRAC_BITS+6+7)/8)*8-1:0] s_tdata,
	// action
	input  logic [1:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// tx_type, tx_hello_id, tx_recipient, tx_partner_msg, level, mode_now, exchange_done
	output logic [((3*ID_BITS+FRAC_BITS+8+7)/8)*8-1:0] m_tdata,
	// result_kind
	output logic                     m_tuser
);
	import hdn_pkg::*;

	localparam int I_SEND = 0;
	localparam int I_RXT  = 1;
	localparam int I_SND  = 3;
	localparam int I_RCP  = 3 + ID_BITS;
	localparam int I_HID  = 4 + 2*ID_BITS;
	localparam int I_PM   = 4 + 3*ID_BITS;
	localparam int I_LVL  = 5 + 4*ID_BITS;

	localparam int O_TT   = 0;
	localparam int O_THID = 2;
	localparam int O_TRCP = 2 + ID_BITS;
	localparam int O_TPM  = 3 + 2*ID_BITS;
	localparam int O_LV   = 4 + 3*ID_BITS;
	localparam int O_MD   = 5 + 3*ID_BITS + FRAC_BITS;
	localparam int O_DN   = 7 + 3*ID_BITS + FRAC_BITS;

	localparam logic [ID_BITS:0]   NO_ADDR     = '1;
	localparam logic [FRAC_BITS:0] KAPPA_RESET = (FRAC_BITS+1)'((9 * (2**FRAC_BITS)) / 10);

	// configuration
	logic [ID_BITS-1:0] node_id_q;
	logic               is_source_q;
	logic [FRAC_BITS:0] kappa_q;
	logic [7:0]         timeout_q;
	logic [3:0]         max_msgs_q;

	// input stage
	logic               valid_s1;
	act_t               action_s1;
	logic               send_s1;
	logic [1:0]         rx_type_s1;
	logic [ID_BITS-1:0] rx_sender_s1;
	logic [ID_BITS:0]   rx_recipient_s1;
	logic [ID_BITS-1:0] rx_hello_id_s1;
	logic [ID_BITS:0]   rx_partner_msg_s1;
	logic [FRAC_BITS:0] rx_conc_s1;

	// node state
	hdn_ctrl_t          ctrl_q;
	logic [FRAC_BITS:0] conc_q;
	logic [ID_BITS:0]   partner_node_q;
	logic [ID_BITS-1:0] partner_seq_q;
	logic [FRAC_BITS:0] partner_level_q;
	logic [ID_BITS-1:0] own_seq_q;

	hdn_ctrl_t          ctrl_nx;
	logic [FRAC_BITS:0] conc_nx;
	logic [ID_BITS:0]   partner_node_nx;
	logic [ID_BITS-1:0] partner_seq_nx;
	logic [FRAC_BITS:0] partner_level_nx;
	logic [ID_BITS-1:0] own_seq_nx;

	logic               res_valid;
	logic               res_kind;
	logic [1:0]         res_tx_type;
	logic [ID_BITS-1:0] res_hello_id;
	logic [ID_BITS:0]   res_recipient;
	logic [ID_BITS:0]   res_partner_msg;
	logic [FRAC_BITS:0] res_level;
	logic [1:0]         res_mode;
	logic               res_done;

	// result register
	logic               out_valid_q;
	logic               out_kind_q;
	logic [1:0]         out_tx_type_q;
	logic [ID_BITS-1:0] out_hello_id_q;
	logic [ID_BITS:0]   out_recipient_q;
	logic [ID_BITS:0]   out_partner_msg_q;
	logic [FRAC_BITS:0] out_level_q;
	logic [1:0]         out_mode_q;
	logic               out_done_q;

	logic stall;
	logic commit;
	logic load_out;

	hdn_step #(.ID_BITS(ID_BITS), .FRAC_BITS(FRAC_BITS)) u_step (
		.action            (action_s1),
		.send_enable       (send_s1),
		.rx_type           (rx_type_s1),
		.rx_sender         (rx_sender_s1),
		.rx_recipient      (rx_recipient_s1),
		.rx_hello_id       (rx_hello_id_s1),
		.rx_partner_msg    (rx_partner_msg_s1),
		.rx_concentration  (rx_conc_s1),
		.node_id           (node_id_q),
		.is_source         (is_source_q),
		.kappa             (kappa_q),
		.handshake_timeout (timeout_q),
		.max_msgs_per_step (max_msgs_q),
		.ctrl              (ctrl_q),
		.conc              (conc_q),
		.partner_node      (partner_node_q),
		.partner_seq       (partner_seq_q),
		.partner_level     (partner_level_q),
		.own_seq           (own_seq_q),
		.ctrl_nx           (ctrl_nx),
		.conc_nx           (conc_nx),
		.partner_node_nx   (partner_node_nx),
		.partner_seq_nx    (partner_seq_nx),
		.partner_level_nx  (partner_level_nx),
		.own_seq_nx        (own_seq_nx),
		.res_valid         (res_valid),
		.res_kind          (res_kind),
		.tx_type           (res_tx_type),
		.tx_hello_id       (res_hello_id),
		.tx_recipient      (res_recipient),
		.tx_partner_msg    (res_partner_msg),
		.level             (res_level),
		.mode_now          (res_mode),
		.exchange_done     (res_done)
	);

	// hold the stage only when its result has nowhere to go
	assign stall    = valid_s1 && res_valid && out_valid_q && !m_tready;
	assign commit   = valid_s1 && !stall;
	assign load_out = commit && res_valid;
	assign s_tready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q   <= '0;
			is_source_q <= 1'b0;
			kappa_q     <= KAPPA_RESET;
			timeout_q   <= TIMEOUT_RESET;
			max_msgs_q  <= MAX_MSGS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_NODE_ID:   node_id_q   <= cfg_wdata[ID_BITS-1:0];
				REG_IS_SOURCE: is_source_q <= cfg_wdata[0];
				REG_KAPPA:     kappa_q     <= cfg_wdata[FRAC_BITS:0];
				REG_TIMEOUT:   timeout_q   <= cfg_wdata[7:0];
				REG_MAX_MSGS:  max_msgs_q  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1         <= act_t'(s_tuser);
			send_s1           <= s_tdata[I_SEND];
			rx_type_s1        <= s_tdata[I_RXT +: 2];
			rx_sender_s1      <= s_tdata[I_SND +: ID_BITS];
			rx_recipient_s1   <= s_tdata[I_RCP +: ID_BITS+1];
			rx_hello_id_s1    <= s_tdata[I_HID +: ID_BITS];
			rx_partner_msg_s1 <= s_tdata[I_PM +: ID_BITS+1];
			rx_conc_s1        <= s_tdata[I_LVL +: FRAC_BITS+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q          <= '{hs: HS_HELLO, wait_steps: '0, msgs_seen: '0,
				step_closed: 1'b0, linked: 1'b0};
			conc_q          <= '0;
			partner_node_q  <= NO_ADDR;
			partner_seq_q   <= '0;
			partner_level_q <= '0;
			own_seq_q       <= '0;
		end else if (commit) begin
			ctrl_q          <= ctrl_nx;
			conc_q          <= conc_nx;
			partner_node_q  <= partner_node_nx;
			partner_seq_q   <= partner_seq_nx;
			partner_level_q <= partner_level_nx;
			own_seq_q       <= own_seq_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kind_q        <= res_kind;
			out_tx_type_q     <= res_tx_type;
			out_hello_id_q    <= res_hello_id;
			out_recipient_q   <= res_recipient;
			out_partner_msg_q <= res_partner_msg;
			out_level_q       <= res_level;
			out_mode_q        <= res_mode;
			out_done_q        <= res_done;
		end
	end

	always_comb begin
		m_tdata                        = '0;
		m_tdata[O_TT +: 2]             = out_tx_type_q;
		m_tdata[O_THID +: ID_BITS]     = out_hello_id_q;
		m_tdata[O_TRCP +: ID_BITS+1]   = out_recipient_q;
		m_tdata[O_TPM +: ID_BITS+1]    = out_partner_msg_q;
		m_tdata[O_LV +: FRAC_BITS+1]   = out_level_q;
		m_tdata[O_MD +: 2]             = out_mode_q;
		m_tdata[O_DN]                  = out_done_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
endmodule

[sv/hdn_diffuse.sv]
// Diffusion update: level + floor(kappa * (partner - level)), clamped to 0..1.0.
module hdn_diffuse #(
	parameter int FRAC_BITS = 16
) (
	input  logic [FRAC_BITS:0] kappa,
	input  logic [FRAC_BITS:0] level,
	input  logic [FRAC_BITS:0] partner_level,
	output logic [FRAC_BITS:0] new_level
);
	localparam logic [FRAC_BITS:0] LVL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic signed [FRAC_BITS+1:0]   diff;
	logic signed [2*FRAC_BITS+3:0] prod;
	logic signed [2*FRAC_BITS+3:0] prod_sh;
	logic signed [FRAC_BITS+3:0]   sum;

	assign diff    = $signed({1'b0, partner_level}) - $signed({1'b0, level});
	assign prod    = (2*FRAC_BITS+4)'($signed({1'b0, kappa})) * (2*FRAC_BITS+4)'(diff);
	// arithmetic shift floors toward minus infinity
	assign prod_sh = prod >>> FRAC_BITS;
	assign sum     = $signed({3'b000, level}) + prod_sh[FRAC_BITS+3:0];

	always_comb begin
		if (sum < 0) begin
			new_level = '0;
		end else if (sum > $signed({3'b000, LVL_ONE})) begin
			new_level = LVL_ONE;
		end else begin
			new_level = sum[FRAC_BITS:0];
		end
	end
endmodule

[sv/hdn_step.sv]
// Per-item next-state and result logic of the node.
module hdn_step #(
	parameter int ID_BITS   = 16,
	parameter int FRAC_BITS = 16
) (
	input  hdn_pkg::act_t       action,
	input  logic                send_enable,
	input  logic [1:0]          rx_type,
	input  logic [ID_BITS-1:0]  rx_sender,
	input  logic [ID_BITS:0]    rx_recipient,
	input  logic [ID_BITS-1:0]  rx_hello_id,
	input  logic [ID_BITS:0]    rx_partner_msg,
	input  logic [FRAC_BITS:0]  rx_concentration,
	input  logic [ID_BITS-1:0]  node_id,
	input  logic                is_source,
	input  logic [FRAC_BITS:0]  kappa,
	input  logic [7:0]          handshake_timeout,
	input  logic [3:0]          max_msgs_per_step,
	input  hdn_pkg::hdn_ctrl_t  ctrl,
	input  logic [FRAC_BITS:0]  conc,
	input  logic [ID_BITS:0]    partner_node,
	input  logic [ID_BITS-1:0]  partner_seq,
	input  logic [FRAC_BITS:0]  partner_level,
	input  logic [ID_BITS-1:0]  own_seq,
	output hdn_pkg::hdn_ctrl_t  ctrl_nx,
	output logic [FRAC_BITS:0]  conc_nx,
	output logic [ID_BITS:0]    partner_node_nx,
	output logic [ID_BITS-1:0]  partner_seq_nx,
	output logic [FRAC_BITS:0]  partner_level_nx,
	output logic [ID_BITS-1:0]  own_seq_nx,
	output logic                res_valid,
	output logic                res_kind,
	output logic [1:0]          tx_type,
	output logic [ID_BITS-1:0]  tx_hello_id,
	output logic [ID_BITS:0]    tx_recipient,
	output logic [ID_BITS:0]    tx_partner_msg,
	output logic [FRAC_BITS:0]  level,
	output logic [1:0]          mode_now,
	output logic                exchange_done
);
	import hdn_pkg::*;

	localparam logic [ID_BITS:0]   NO_ADDR = '1;
	localparam logic [FRAC_BITS:0] LVL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [FRAC_BITS:0] diffused;
	logic               to_me;
	logic               ack_match;
	logic               has_partner;
	logic               from_partner;
	logic [7:0]         wait_inc;
	logic               timed_out;
	logic               link;
	logic               finish;

	hdn_diffuse #(.FRAC_BITS(FRAC_BITS)) u_diffuse (
		.kappa         (kappa),
		.level         (conc),
		.partner_level (partner_level),
		.new_level     (diffused)
	);

	assign to_me        = (rx_recipient == {1'b0, node_id});
	assign ack_match    = (rx_partner_msg == {1'b0, own_seq});
	assign has_partner  = (partner_node != NO_ADDR);
	assign from_partner = (partner_node == {1'b0, rx_sender});
	assign wait_inc     = (ctrl.wait_steps == WAIT_MAX) ? WAIT_MAX : ctrl.wait_steps + 8'd1;
	assign timed_out    = (wait_inc >= handshake_timeout);
	assign link         = ctrl.linked || (ctrl.hs == HS_OK && timed_out);
	assign finish       = link || (ctrl.hs == HS_ACK && timed_out);

	always_comb begin
		ctrl_nx          = ctrl;
		conc_nx          = conc;
		partner_node_nx  = partner_node;
		partner_seq_nx   = partner_seq;
		partner_level_nx = partner_level;
		own_seq_nx       = own_seq;
		res_valid        = 1'b0;
		res_kind         = KIND_TX;
		tx_type          = MSG_HELLO;
		tx_hello_id      = '0;
		tx_recipient     = '0;
		tx_partner_msg   = '0;
		exchange_done    = 1'b0;

		unique case (action)
			ACT_RUN_START: begin
				ctrl_nx          = '{hs: HS_HELLO, wait_steps: '0, msgs_seen: '0,
					step_closed: 1'b0, linked: 1'b0};
				conc_nx          = is_source ? LVL_ONE : '0;
				partner_node_nx  = NO_ADDR;
				partner_seq_nx   = '0;
				partner_level_nx = '0;
				own_seq_nx       = '0;
			end
			ACT_STEP_START: begin
				res_valid   = send_enable;
				tx_hello_id = own_seq;
				unique case (ctrl.hs)
					HS_ACK: begin
						tx_type        = MSG_ACK;
						tx_recipient   = partner_node;
						tx_partner_msg = {1'b0, partner_seq};
					end
					HS_OK: begin
						tx_type        = MSG_OK;
						tx_recipient   = partner_node;
						tx_partner_msg = NO_ADDR;
					end
					default: begin
						tx_type        = MSG_HELLO;
						tx_recipient   = NO_ADDR;
						tx_partner_msg = NO_ADDR;
					end
				endcase
			end
			ACT_RX_MSG: begin
				if (!ctrl.step_closed && ctrl.msgs_seen < max_msgs_per_step) begin
					ctrl_nx.msgs_seen = ctrl.msgs_seen + 4'd1;
					if (!has_partner || from_partner) begin
						unique case (ctrl.hs)
							HS_HELLO: begin
								if (rx_type == MSG_HELLO) begin
									if (!has_partner)
										partner_node_nx = {1'b0, rx_sender};
									partner_seq_nx      = rx_hello_id;
									partner_level_nx    = rx_concentration;
									ctrl_nx.hs          = HS_ACK;
									ctrl_nx.wait_steps  = '0;
									ctrl_nx.step_closed = 1'b1;
								end else if (rx_type == MSG_ACK && to_me && ack_match) begin
									partner_node_nx     = {1'b0, rx_sender};
									partner_seq_nx      = rx_hello_id;
									partner_level_nx    = rx_concentration;
									ctrl_nx.hs          = HS_OK;
									ctrl_nx.wait_steps  = '0;
									ctrl_nx.step_closed = 1'b1;
								end
							end
							HS_ACK: begin
								if (rx_type == MSG_OK && to_me && rx_hello_id == partner_seq) begin
									ctrl_nx.linked      = 1'b1;
									ctrl_nx.step_closed = 1'b1;
								end else if (rx_type == MSG_ACK && from_partner && to_me
									&& ack_match) begin
									ctrl_nx.hs          = HS_OK;
									ctrl_nx.wait_steps  = '0;
									ctrl_nx.step_closed = 1'b1;
								end
							end
							HS_OK: begin
								if (rx_type == MSG_HELLO) begin
									ctrl_nx.linked      = 1'b1;
									ctrl_nx.step_closed = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
			end
			ACT_STEP_END: begin
				res_valid          = 1'b1;
				res_kind           = KIND_STATUS;
				exchange_done      = finish;
				ctrl_nx.wait_steps = wait_inc;
				if (link)
					conc_nx = diffused;
				if (finish) begin
					own_seq_nx         = own_seq + ID_BITS'(1);
					partner_node_nx    = NO_ADDR;
					partner_seq_nx     = '0;
					partner_level_nx   = '0;
					ctrl_nx.hs         = HS_HELLO;
					ctrl_nx.wait_steps = '0;
				end
				ctrl_nx.msgs_seen   = '0;
				ctrl_nx.step_closed = 1'b0;
				ctrl_nx.linked      = 1'b0;
			end
			default: ;
		endcase
	end

	assign level    = conc_nx;
	assign mode_now = ctrl_nx.hs;
endmodule

[sv/hdn_checker.sv]
// Port-level checks on the node's result stream, bound to the top level.
module hdn_checker #(
	parameter int ID_BITS   = 16,
	parameter int FRAC_BITS = 16
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [((3*ID_BITS+FRAC_BITS+8+7)/8)*8-1:0] m_tdata,
	input logic                     m_tuser
);
	import hdn_pkg::*;

	localparam int O_THID = 2;
	localparam int O_LV   = 4 + 3*ID_BITS;
	localparam int O_MD   = 5 + 3*ID_BITS + FRAC_BITS;
	localparam int O_DN   = 7 + 3*ID_BITS + FRAC_BITS;
	localparam logic [FRAC_BITS:0] LVL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic               is_status;
	logic               done;
	logic [1:0]         mode;
	logic [FRAC_BITS:0] lvl;

	assign is_status = (m_tuser == KIND_STATUS);
	assign done      = m_tdata[O_DN];
	assign mode      = m_tdata[O_MD +: 2];
	assign lvl       = m_tdata[O_LV +: FRAC_BITS+1];

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat dropped or changed while stalled");

	a_done_back_to_hello: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && is_status && done |-> mode == HS_HELLO)
		else $error("finished exchange did not return to hello");

	a_tx_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !is_status |-> !done)
		else $error("transmit beat flags a finished exchange");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> lvl <= LVL_ONE)
		else $error("concentration above 1.0");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && is_status |-> m_tdata[O_LV-1:0] == '0)
		else $error("status beat carries message fields");
endmodule

bind handshake_diffusion_node_core hdn_checker #(
	.ID_BITS   (ID_BITS),
	.FRAC_BITS (FRAC_BITS)
) u_hdn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[dv/testbench.sv]
// Self-checking testbench for the handshake diffusion node core.
`timescale 1ns / 100ps

module testbench;
	import hdn_pkg::*;

	localparam int           FRAC_BITS   = 16;
	localparam longint       LVL_ONE     = 65536;
	localparam logic [16:0]  NO_PEER     = 17'h1FFFF;
	localparam logic [16:0]  KAPPA_RESET = 17'd58982;
	localparam int           CYCLE_LIMIT = 400000;

	typedef struct packed {
		act_t        action;
		logic        send_en;
		logic [1:0]  rx_type;
		logic [15:0] sender;
		logic [16:0] rcp;
		logic [15:0] hid;
		logic [16:0] pmsg;
		logic [16:0] lvl;
	} node_item_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  tx_type;
		logic [15:0] hid;
		logic [16:0] rcp;
		logic [16:0] pmsg;
		logic [16:0] level;
		hs_t         mode;
		logic        done;
	} node_result_t;

	typedef struct packed {
		node_item_t   item;
		logic         typed;
		node_result_t want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [16:0]          cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// send_enable, rx_type, rx_sender, rx_recipient, rx_hello_id, rx_partner_msg,
	// rx_concentration, zero fill
	logic [87:0]          s_tdata = '0;
	// action
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// tx_type, tx_hello_id, tx_recipient, tx_partner_msg, level, mode_now, exchange_done
	logic [71:0]          m_tdata;
	// result_kind
	logic                 m_tuser;

	handshake_diffusion_node_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// register copies
	logic [15:0] cfg_node  = 16'd0;
	logic        cfg_src   = 1'b0;
	logic [16:0] cfg_kappa = KAPPA_RESET;
	logic [7:0]  cfg_tmo   = TIMEOUT_RESET;
	logic [3:0]  cfg_max   = MAX_MSGS_RESET;

	// node state as predicted
	logic [16:0] lvl_now    = '0;
	logic [16:0] peer       = NO_PEER;
	logic [15:0] peer_seq   = '0;
	logic [16:0] peer_lvl   = '0;
	hs_t         hs_now     = HS_HELLO;
	logic [7:0]  wait_cnt   = '0;
	logic [15:0] own_seq    = '0;
	logic [3:0]  msg_cnt    = '0;
	logic        closed     = 1'b0;
	logic        linked_now = 1'b0;

	node_result_t expected_results[$];
	int           mismatches = 0;
	int           snd_idle_pct = 0;
	int           rcv_idle_pct = 0;
	int unsigned  cycles = 0;

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	function automatic node_item_t beat(input act_t a, input bit s, input logic [1:0] t,
			input int snd, input int rcp, input int hid, input int pmsg, input int lvl);
		node_item_t it;
		it.action  = a;
		it.send_en = s;
		it.rx_type = t;
		it.sender  = 16'(snd);
		it.rcp     = 17'(rcp);
		it.hid     = 16'(hid);
		it.pmsg    = 17'(pmsg);
		it.lvl     = 17'(lvl);
		return it;
	endfunction

	function automatic node_item_t scrambled_beat(input act_t a);
		node_item_t it;
		int pick;
		it.action  = a;
		it.send_en = 1'($urandom_range(0, 1));
		it.rx_type = 2'($urandom_range(0, 3));
		it.sender  = 16'($urandom_range(0, 65535));
		it.rcp     = ($urandom_range(0, 4) == 0) ? NO_PEER : 17'($urandom_range(0, 65535));
		it.hid     = 16'($urandom_range(0, 65535));
		it.pmsg    = ($urandom_range(0, 4) == 0) ? NO_PEER : 17'($urandom_range(0, 65535));
		pick = int'($urandom_range(0, 9));
		it.lvl     = (pick == 0) ? 17'd0 : (pick == 1) ? 17'd65536
			: 17'($urandom_range(0, 65536));
		return it;
	endfunction

	function automatic node_result_t outcome(input logic k, input logic [1:0] t,
			input int hid, input int rcp, input int pmsg, input int lvl, input hs_t m,
			input logic d);
		node_result_t r;
		r.kind    = k;
		r.tx_type = t;
		r.hid     = 16'(hid);
		r.rcp     = 17'(rcp);
		r.pmsg    = 17'(pmsg);
		r.level   = 17'(lvl);
		r.mode    = m;
		r.done    = d;
		return r;
	endfunction

	// Updates the predicted node state for one beat; returns 1 when a result is due.
	function automatic bit advance_node(input node_item_t it, output node_result_t r);
		bit     made;
		logic   to_me;
		logic   fin;
		longint base;
		longint delta;
		longint gain;
		longint stepped;
		made = 1'b0;
		r = '0;
		case (it.action)
		ACT_RUN_START: begin
			peer       = NO_PEER;
			peer_seq   = '0;
			peer_lvl   = '0;
			hs_now     = HS_HELLO;
			wait_cnt   = '0;
			own_seq    = '0;
			msg_cnt    = '0;
			closed     = 1'b0;
			linked_now = 1'b0;
			lvl_now    = cfg_src ? 17'd65536 : 17'd0;
		end
		ACT_STEP_START: begin
			if (it.send_en) begin
				made    = 1'b1;
				r.kind  = KIND_TX;
				r.hid   = own_seq;
				r.level = lvl_now;
				r.mode  = hs_now;
				case (hs_now)
				HS_ACK: begin
					r.tx_type = MSG_ACK;
					r.rcp     = peer;
					r.pmsg    = {1'b0, peer_seq};
				end
				HS_OK: begin
					r.tx_type = MSG_OK;
					r.rcp     = peer;
					r.pmsg    = NO_PEER;
				end
				default: begin
					r.tx_type = MSG_HELLO;
					r.rcp     = NO_PEER;
					r.pmsg    = NO_PEER;
				end
				endcase
			end
		end
		ACT_RX_MSG: begin
			to_me = (it.rcp == {1'b0, cfg_node});
			if (!closed && msg_cnt < cfg_max) begin
				msg_cnt++;
				// strangers are counted but never acted on
				if (peer == NO_PEER || peer == {1'b0, it.sender}) begin
					case (hs_now)
					HS_HELLO: begin
						if (it.rx_type == MSG_HELLO) begin
							if (peer == NO_PEER)
								peer = {1'b0, it.sender};
							peer_seq = it.hid;
							peer_lvl = it.lvl;
							hs_now   = HS_ACK;
							wait_cnt = '0;
							closed   = 1'b1;
						end else if (it.rx_type == MSG_ACK && to_me
								&& it.pmsg == {1'b0, own_seq}) begin
							peer     = {1'b0, it.sender};
							peer_lvl = it.lvl;
							peer_seq = it.hid;
							hs_now   = HS_OK;
							wait_cnt = '0;
							closed   = 1'b1;
						end
					end
					HS_ACK: begin
						if (it.rx_type == MSG_OK && to_me && it.hid == peer_seq) begin
							linked_now = 1'b1;
							closed     = 1'b1;
						end else if (it.rx_type == MSG_ACK && peer == {1'b0, it.sender}
								&& to_me && it.pmsg == {1'b0, own_seq}) begin
							hs_now   = HS_OK;
							wait_cnt = '0;
							closed   = 1'b1;
						end
					end
					HS_OK: begin
						if (it.rx_type == MSG_HELLO) begin
							linked_now = 1'b1;
							closed     = 1'b1;
						end
					end
					default: ;
					endcase
				end
			end
		end
		default: begin
			fin = 1'b0;
			if (wait_cnt != WAIT_MAX)
				wait_cnt++;
			if (hs_now == HS_OK && wait_cnt >= cfg_tmo)
				linked_now = 1'b1;
			if (linked_now) begin
				// floor of kappa * (partner - own), then clamp to 0..1.0
				base    = longint'(lvl_now);
				delta   = longint'(peer_lvl);
				gain    = longint'(cfg_kappa);
				delta   = (delta - base) * gain;
				stepped = base + (delta >>> FRAC_BITS);
				if (stepped < 0)
					stepped = 0;
				else if (stepped > LVL_ONE)
					stepped = LVL_ONE;
				lvl_now = stepped[16:0];
				fin     = 1'b1;
			end else if (hs_now == HS_ACK && wait_cnt >= cfg_tmo) begin
				fin = 1'b1;
			end
			if (fin) begin
				own_seq  = own_seq + 16'd1;
				peer     = NO_PEER;
				peer_seq = '0;
				peer_lvl = '0;
				hs_now   = HS_HELLO;
				wait_cnt = '0;
			end
			msg_cnt    = '0;
			closed     = 1'b0;
			linked_now = 1'b0;
			made       = 1'b1;
			r.kind     = KIND_STATUS;
			r.level    = lvl_now;
			r.mode     = hs_now;
			r.done     = fin;
		end
		endcase
		return made;
	endfunction

	// Offers one beat after a random gap; valid stays up into the next call.
	task automatic offer(input node_item_t it, input bit typed, input node_result_t want);
		node_result_t r;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.action;
		s_tdata  <= {2'b00, it.lvl, it.pmsg, it.hid, it.rcp, it.sender, it.rx_type,
			it.send_en};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (advance_node(it, r))
			expected_results.push_back(typed ? want : r);
	endtask

	task automatic load_config(input logic [15:0] node, input logic src,
			input logic [16:0] kap, input logic [7:0] tmo, input logic [3:0] maxm);
		logic [CFG_IDX_W-1:0] idx[5];
		logic [16:0]          val[5];
		idx = '{REG_NODE_ID, REG_IS_SOURCE, REG_KAPPA, REG_TIMEOUT, REG_MAX_MSGS};
		val = '{{1'b0, node}, {16'd0, src}, kap, {9'd0, tmo}, {13'd0, maxm}};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		cfg_node  = node;
		cfg_src   = src;
		cfg_kappa = kap;
		cfg_tmo   = tmo;
		cfg_max   = maxm;
	endtask

	// Random steps: mostly handshake traffic shaped to the predicted state, some noise.
	task automatic run_phase(input int n_items, input int snd_pct, input int rcv_pct);
		node_item_t it;
		int         count;
		int         msgs;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		offer(scrambled_beat(ACT_RUN_START), 1'b0, '0);
		count = 1;
		while (count < n_items) begin
			if ($urandom_range(0, 99) < 3) begin
				offer(scrambled_beat(ACT_RUN_START), 1'b0, '0);
				count++;
			end
			if ($urandom_range(0, 9) != 0) begin
				offer(scrambled_beat(ACT_STEP_START), 1'b0, '0);
				count++;
			end
			msgs = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 17))
				: int'($urandom_range(0, 3));
			repeat (msgs) begin
				it = scrambled_beat(ACT_RX_MSG);
				if ($urandom_range(0, 3) != 0) begin
					case (hs_now)
					HS_HELLO: begin
						if ($urandom_range(0, 1)) begin
							it.rx_type = MSG_HELLO;
							it.rcp     = NO_PEER;
						end else begin
							it.rx_type = MSG_ACK;
							it.rcp     = {1'b0, cfg_node};
							it.pmsg    = {1'b0, own_seq};
						end
					end
					HS_ACK: begin
						it.sender = peer[15:0];
						it.rcp    = {1'b0, cfg_node};
						if ($urandom_range(0, 1)) begin
							it.rx_type = MSG_OK;
							it.hid     = peer_seq;
						end else begin
							it.rx_type = MSG_ACK;
							it.pmsg    = {1'b0, own_seq};
						end
					end
					default: begin
						it.sender  = peer[15:0];
						it.rx_type = MSG_HELLO;
					end
					endcase
				end else begin
					if (peer != NO_PEER && $urandom_range(0, 1))
						it.sender = peer[15:0];
					case ($urandom_range(0, 2))
					0: it.rcp = NO_PEER;
					1: it.rcp = {1'b0, cfg_node};
					default: ;
					endcase
					case ($urandom_range(0, 2))
					0: it.pmsg = NO_PEER;
					1: it.pmsg = {1'b0, own_seq};
					default: ;
					endcase
				end
				offer(it, 1'b0, '0);
				count++;
			end
			offer(scrambled_beat(ACT_STEP_END), 1'b0, '0);
			count++;
		end
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

	always @(posedge clk) begin : result_check
		node_result_t got;
		node_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind    = m_tuser;
			got.tx_type = m_tdata[1:0];
			got.hid     = m_tdata[17:2];
			got.rcp     = m_tdata[34:18];
			got.pmsg    = m_tdata[51:35];
			got.level   = m_tdata[68:52];
			got.mode    = hs_t'(m_tdata[70:69]);
			got.done    = m_tdata[71];
			if (expected_results.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				want = expected_results.pop_front();
				check_field("result_kind", longint'(got.kind), longint'(want.kind));
				check_field("tx_type", longint'(got.tx_type), longint'(want.tx_type));
				check_field("tx_hello_id", longint'(got.hid), longint'(want.hid));
				check_field("tx_recipient", longint'(got.rcp), longint'(want.rcp));
				check_field("tx_partner_msg", longint'(got.pmsg), longint'(want.pmsg));
				check_field("level", longint'(got.level), longint'(want.level));
				check_field("mode_now", longint'(got.mode), longint'(want.mode));
				check_field("exchange_done", longint'(got.done), longint'(want.done));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL handshake_diffusion_node_core");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		int   drain;
		rows.push_back('{item: beat(ACT_STEP_END, 1'b0, MSG_HELLO, 0, 0, 0, 0, 0), typed: 1'b1,
			want: outcome(KIND_STATUS, 2'd0, 0, 0, 0, 0, HS_HELLO, 1'b0)});
		rows.push_back('{item: beat(ACT_STEP_START, 1'b1, MSG_HELLO, 0, 0, 0, 0, 0), typed: 1'b1,
			want: outcome(KIND_TX, MSG_HELLO, 0, -1, -1, 0, HS_HELLO, 1'b0)});
		rows.push_back('{beat(ACT_STEP_START, 1'b0, MSG_OK, 1, 1, 1, 1, 1), 1'b0, '0});
		rows.push_back('{beat(ACT_RUN_START, 1'b1, MSG_ACK, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, MSG_HELLO, 5, -1, 7, -1, 65536), 1'b0, '0});
		// step already closed by the first HELLO
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, MSG_HELLO, 9, -1, 3, -1, 100), 1'b0, '0});
		rows.push_back('{item: beat(ACT_STEP_START, 1'b1, MSG_HELLO, 0, 0, 0, 0, 0), typed: 1'b1,
			want: outcome(KIND_TX, MSG_ACK, 0, 5, 7, 0, HS_ACK, 1'b0)});
		rows.push_back('{beat(ACT_STEP_END, 1'b0, MSG_HELLO, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, MSG_HELLO, 9, 0, 7, -1, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, 2'd3, 5, 0, 7, 0, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, MSG_OK, 5, -1, 7, -1, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, MSG_OK, 5, 0, 8, -1, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, MSG_OK, 5, 0, 7, -1, 0), 1'b0, '0});
		rows.push_back('{item: beat(ACT_STEP_END, 1'b1, MSG_HELLO, 0, 0, 0, 0, 0), typed: 1'b1,
			want: outcome(KIND_STATUS, 2'd0, 0, 0, 0, 58982, HS_HELLO, 1'b1)});
		// negative acknowledged sequence never matches
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, MSG_ACK, 3, 0, 20, -1, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, MSG_ACK, 3, 0, 20, 1, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_STEP_START, 1'b1, MSG_HELLO, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, MSG_HELLO, 3, -1, 21, -1, 65536), 1'b0, '0});
		rows.push_back('{beat(ACT_STEP_END, 1'b0, MSG_HELLO, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_RX_MSG, 1'b1, MSG_HELLO, 65535, 65535, 65535, 65535, 65536),
			1'b0, '0});
		rows.push_back('{beat(ACT_RX_MSG, 1'b0, MSG_OK, 65535, 0, 65535, -1, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_STEP_END, 1'b0, MSG_HELLO, 0, 0, 0, 0, 0), 1'b0, '0});
		rows.push_back('{beat(ACT_STEP_START, 1'b1, 2'd3, 65535, -1, 65535, -1, 65536), 1'b0, '0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 34;
		rcv_idle_pct = 71;
		foreach (rows[i])
			offer(rows[i].item, rows[i].typed, rows[i].want);

		for (int p = 0; p < 6; p++) begin
			s_tvalid <= 1'b0;
			while (expected_results.size() != 0)
				@(posedge clk);
			// a trailing beat with no result may still be in flight
			repeat (4) @(posedge clk);
			case (p)
			0: load_config(16'd0, 1'b0, 17'd0, 8'd1, 4'd1);
			1: load_config(16'hFFFF, 1'b1, 17'd65536, 8'd255, 4'd15);
			default: load_config(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
				17'($urandom_range(0, 65536)), 8'($urandom_range(1, 8)),
				4'($urandom_range(1, 15)));
			endcase
			run_phase(190, (p < 2) ? 34 : (p < 4) ? 71 : 0, (p < 2) ? 71 : (p < 4) ? 34 : 0);
		end
		s_tvalid <= 1'b0;

		drain = 0;
		while (expected_results.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		if (expected_results.size() != 0)
			report($sformatf("%0d expected results never arrived", expected_results.size()));
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS handshake_diffusion_node_core");
		else
			$display("FAIL handshake_diffusion_node_core");
		$finish;
	end

endmodule

[filelist.f]
sv/hdn_pkg.sv
sv/hdn_diffuse.sv
sv/hdn_step.sv
sv/handshake_diffusion_node_core.sv
sv/hdn_checker.sv
dv/testbench.sv
